// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the linked ring queue unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define LRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define LRQ_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define LRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/lrq_pkg.sv -----
// Types, codes and semaphore helpers of the linked ring queue unit.
package lrq_pkg;

	localparam int ENTRY_W = 6;
	localparam int QID_W   = 3;
	localparam int COUNT_W = 8;

	typedef enum logic [1:0] {
		KIND_ENQ = 2'd0,
		KIND_DEQ = 2'd1,
		KIND_P   = 2'd2,
		KIND_V   = 2'd3
	} kind_t;

	localparam logic signed [COUNT_W-1:0] SEM_RESET = 8'sd1;
	localparam logic signed [COUNT_W-1:0] SEM_MIN   = 8'sh80;
	localparam logic signed [COUNT_W-1:0] SEM_MAX   = 8'sh7F;

	typedef struct packed {
		kind_t               kind;
		logic [QID_W-1:0]    queue_id;
		logic [ENTRY_W-1:0]  entry_id;
	} in_item_t;

	typedef struct packed {
		logic [ENTRY_W-1:0]         out_entry;
		logic                       out_valid;
		logic                       blocked;
		logic signed [COUNT_W-1:0]  count_after;
	} out_item_t;

	// One word of the per-queue memory.
	typedef struct packed {
		logic [ENTRY_W-1:0]         tail;
		logic signed [COUNT_W-1:0]  sem;
	} qword_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_QRD  = 6'b000010,
		ST_LNK  = 6'b000100,
		ST_WR2  = 6'b001000,
		ST_DQ2  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	function automatic logic signed [COUNT_W-1:0] sem_dec(
		input logic signed [COUNT_W-1:0] s);
		return (s == SEM_MIN) ? s : s - 8'sd1;
	endfunction

	function automatic logic signed [COUNT_W-1:0] sem_inc(
		input logic signed [COUNT_W-1:0] s);
		return (s == SEM_MAX) ? s : s + 8'sd1;
	endfunction

endpackage

// ----- rtl/lrq_in_if.sv -----
// Request channel of the linked ring queue unit.
interface lrq_in_if;
	import lrq_pkg::*;

	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/lrq_out_if.sv -----
// Result channel of the linked ring queue unit.
interface lrq_out_if;
	import lrq_pkg::*;

	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/linked_ring_queue_semaphore_unit.sv -----
// Linked ring queue manager with one counting semaphore per queue: top level.
// Requests are taken one at a time. After the per-queue word is read in ST_QRD, an
// item that needs no link read (enqueue into an empty queue, dequeue from an empty
// queue, a P that does not block, a V that wakes no one) goes straight to ST_DONE;
// a dequeue or wake that empties the queue passes ST_LNK, an enqueue or block into a
// non-empty queue passes ST_LNK and ST_WR2, and a dequeue that leaves entries behind
// passes ST_LNK and ST_DQ2. The path is set by the next-link memory: one read and
// one write per cycle, with a registered read, while a request may need a read of
// the tail's link, a read of the head's link and two link writes. The next request
// is accepted the cycle after the result is loaded into the output register, even
// if that beat has not yet been taken. Tails and semaphore counts live in a
// per-queue memory; a count that was never written reads as its reset value of one.
module linked_ring_queue_semaphore_unit #(
	parameter int NUM_QUEUES  = 8,
	parameter int NUM_ENTRIES = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	lrq_in_if.sink    req,
	lrq_out_if.source rsp
);
	import lrq_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
	localparam int QWORD_W = $bits(qword_t);

	state_t                      state_q;
	kind_t                       kind_q;
	logic [QID_W-1:0]            qid_q;
	logic [ENTRY_W-1:0]          ent_q;
	logic                        q_ok_q;
	logic                        e_ok_q;
	logic [ENTRY_W-1:0]          tail_q;
	logic                        enq_q;
	logic                        blk_q;
	logic                        got_valid_q;
	logic [ENTRY_W-1:0]          got_q;
	logic signed [COUNT_W-1:0]   sem_q;
	logic [NUM_QUEUES-1:0]       nonempty_q;
	logic [NUM_QUEUES-1:0]       qwr_q;
	out_item_t                   out_q;
	logic                        out_full_q;

	logic                        qram_we;
	qword_t                      qram_wdata;
	logic [QWORD_W-1:0]          qram_rdata;
	qword_t                      qw;
	logic                        lram_we;
	logic [EW-1:0]               lram_waddr;
	logic [ENTRY_W-1:0]          lram_wdata;
	logic [EW-1:0]               lram_raddr;
	logic [ENTRY_W-1:0]          lram_rdata;

	logic [QW-1:0]               qidx;
	logic signed [COUNT_W-1:0]   sem_old;
	logic signed [COUNT_W-1:0]   sem_new;
	logic                        want_enq;
	logic                        want_deq;
	logic                        load_out;
	logic                        accept;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!out_full_q || rsp.ready);
	assign rsp.valid = out_full_q;
	assign rsp.data  = out_q;

	assign qidx = QW'(qid_q);
	assign qw   = qword_t'(qram_rdata);

	lrq_ram #(
		.WIDTH(QWORD_W),
		.DEPTH(NUM_QUEUES)
	) u_qram (
		.clk  (clk),
		.we   (qram_we),
		.waddr(qidx),
		.wdata(qram_wdata),
		.raddr(QW'(req.data.queue_id)),
		.rdata(qram_rdata)
	);

	lrq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(NUM_ENTRIES)
	) u_lram (
		.clk  (clk),
		.we   (lram_we),
		.waddr(lram_waddr),
		.wdata(lram_wdata),
		.raddr(lram_raddr),
		.rdata(lram_rdata)
	);

	// Semaphore update and the ring operation it calls for.
	always_comb begin
		sem_old  = qwr_q[qidx] ? qw.sem : SEM_RESET;
		sem_new  = sem_old;
		want_enq = 1'b0;
		want_deq = 1'b0;
		case (kind_q)
			KIND_ENQ: begin
				want_enq = e_ok_q;
			end
			KIND_DEQ: begin
				want_deq = 1'b1;
			end
			KIND_P: begin
				if (e_ok_q) begin
					sem_new  = sem_dec(sem_old);
					want_enq = sem_new[COUNT_W-1];
				end
			end
			KIND_V: begin
				sem_new  = sem_inc(sem_old);
				want_deq = sem_new[COUNT_W-1] || (sem_new == '0);
			end
			default: begin
				want_enq = 1'b0;
			end
		endcase
	end

	// Memory port control.
	always_comb begin
		qram_we    = (state_q == ST_QRD) && q_ok_q;
		qram_wdata = '{tail: (want_enq ? ent_q : qw.tail), sem: sem_new};
		lram_we    = 1'b0;
		lram_waddr = EW'(tail_q);
		lram_wdata = ent_q;
		lram_raddr = EW'(tail_q);
		case (state_q)
			ST_QRD: begin
				lram_raddr = EW'(qw.tail);
				if (q_ok_q && want_enq && !nonempty_q[qidx]) begin
					lram_we    = 1'b1;
					lram_waddr = EW'(ent_q);
					lram_wdata = ent_q;
				end
			end
			ST_LNK: begin
				lram_raddr = EW'(lram_rdata);
				if (enq_q) begin
					lram_we    = 1'b1;
					lram_waddr = EW'(ent_q);
					lram_wdata = lram_rdata;
				end
			end
			ST_WR2: begin
				lram_we    = 1'b1;
				lram_waddr = EW'(tail_q);
				lram_wdata = ent_q;
			end
			ST_DQ2: begin
				lram_we    = 1'b1;
				lram_waddr = EW'(tail_q);
				lram_wdata = lram_rdata;
			end
			default: begin
				lram_we = 1'b0;
			end
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nonempty_q  <= '0;
			qwr_q       <= '0;
			out_full_q  <= 1'b0;
			enq_q       <= 1'b0;
			blk_q       <= 1'b0;
			got_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_full_q <= 1'b1;
			end else if (rsp.ready) begin
				out_full_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						got_valid_q <= 1'b0;
						blk_q       <= 1'b0;
						enq_q       <= 1'b0;
						state_q     <= ST_QRD;
					end
				end
				ST_QRD: begin
					state_q <= ST_DONE;
					if (q_ok_q) begin
						qwr_q[qidx] <= 1'b1;
						enq_q       <= want_enq;
						blk_q       <= want_enq && (kind_q == KIND_P);
						if (want_enq) begin
							if (nonempty_q[qidx]) begin
								state_q <= ST_LNK;
							end else begin
								nonempty_q[qidx] <= 1'b1;
							end
						end else if (want_deq && nonempty_q[qidx]) begin
							state_q <= ST_LNK;
						end
					end
				end
				ST_LNK: begin
					if (enq_q) begin
						state_q <= ST_WR2;
					end else begin
						got_valid_q <= 1'b1;
						// A head that is its own tail was the only entry.
						if (lram_rdata == tail_q) begin
							nonempty_q[qidx] <= 1'b0;
							state_q          <= ST_DONE;
						end else begin
							state_q <= ST_DQ2;
						end
					end
				end
				ST_WR2: begin
					state_q <= ST_DONE;
				end
				ST_DQ2: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.data.kind;
			qid_q  <= req.data.queue_id;
			ent_q  <= req.data.entry_id;
			q_ok_q <= (32'(req.data.queue_id) < NUM_QUEUES);
			e_ok_q <= (32'(req.data.entry_id) < NUM_ENTRIES);
			sem_q  <= '0;
			got_q  <= '0;
		end
		if (state_q == ST_QRD) begin
			tail_q <= qw.tail;
			if (q_ok_q) begin
				sem_q <= sem_new;
			end
		end
		if (state_q == ST_LNK) begin
			got_q <= lram_rdata;
		end
		if (load_out) begin
			out_q.out_entry   <= got_valid_q ? got_q : '0;
			out_q.out_valid   <= got_valid_q;
			out_q.blocked     <= blk_q;
			out_q.count_after <= sem_q;
		end
	end

	`include "assert_macros.svh"

	`LRQ_ASSERT_NOW(a_blocked_negative, clk, arst_n, rsp.valid && rsp.data.blocked, rsp.data.count_after[COUNT_W-1])
	`LRQ_ASSERT_NOW(a_wake_xor_block, clk, arst_n, rsp.valid, !(rsp.data.out_valid && rsp.data.blocked))
	`LRQ_ASSERT_NOW(a_no_link_write_idle, clk, arst_n, lram_we, (state_q != ST_IDLE) && (state_q != ST_DONE))
	`LRQ_ASSERT_NEXT(a_load_from_done, clk, arst_n, load_out, out_full_q && (state_q == ST_IDLE))

endmodule

// ----- rtl/lrq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module lrq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
